FILE: rtl/ascii_command_pwm_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef ASCII_COMMAND_PWM_CONTROLLER_ASSERT_SVH
`define ASCII_COMMAND_PWM_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define APC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apc check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define APC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apc check failed");

`endif

FILE: rtl/apc_pkg.sv
// Package: shared constants and control/status types of the command PWM controller.
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_O    = 8'h4F;

  localparam logic        OP_BYTE = 1'b0;
  localparam logic        OP_TICK = 1'b1;

  localparam logic [0:0]  REG_DEF_PRESC  = 1'b0;
  localparam logic [0:0]  REG_DEF_RELOAD = 1'b1;

  localparam logic [18:0] DIV_DIVIDEND   = 19'd480000;
  localparam logic [15:0] Z_MIN          = 16'd10;
  localparam logic [15:0] Z_MAX          = 16'd50000;
  localparam logic [15:0] P_MAX          = 16'd36000;
  localparam logic [15:0] ARG_SAT        = 16'd65535;
  localparam logic [7:0]  CMP_PULSE      = 8'd100;
  localparam logic [7:0]  CMP_FULL       = 8'd100;
  localparam logic [7:0]  CMP_SERVO_MAX  = 8'd200;
  localparam logic [18:0] SERVO_PRESC    = 19'd959;
  localparam logic [15:0] SERVO_RELOAD   = 16'd999;
  localparam logic [15:0] RELOAD_RST     = 16'd99;
  localparam int          DIV_STEPS      = 19;

  typedef struct packed {
    logic capture;   // latch the incoming item
    logic exec;      // apply framing, command and tick updates
    logic div_start; // launch the prescaler division
    logic div_load;  // write the quotient into the prescaler
  } ctrl_cmd_t;

  typedef struct packed {
    logic z_cmd;     // the held item executes a Z command
    logic div_done;  // quotient ready
  } ctrl_stat_t;
endpackage
`default_nettype wire

FILE: rtl/ascii_command_pwm_controller.sv
// A result is valid in S_OUT, after the item passes S_IDLE (capture) and S_EXEC; a Z command
// also passes S_DIV for the 19-step prescaler division.
// One item in flight: no new item is taken until the result has been accepted from S_OUT.
// Reset (rst, synchronous): frame idle, settings cleared, prescaler 0, reload 99,
// default registers back to 0 and 99.
`timescale 1ns / 1ps
`default_nettype none
module ascii_command_pwm_controller #(
  parameter int FRAME_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // rx_byte[7:0], input_level[8], rpm_value[28:9], zero
  input  wire logic        s_tuser,  // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // compare_value[7:0], active_low[8], prescaler[27:9],
                                     // reload[43:28], servo_mode[44], timer_restart[45],
                                     // reply_valid[46], reply_value[66:47], zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import apc_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_stat_t  stat;
  logic [15:0] def_presc, def_reload, z_divisor;
  logic        div_done;
  logic [18:0] div_quot;
  logic [7:0]  compare_value;
  logic        active_low, servo_mode, timer_restart, reply_valid;
  logic [18:0] prescaler;
  logic [15:0] reload;
  logic [19:0] reply_value;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_presc  <= '0;
      def_reload <= RELOAD_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_DEF_RELOAD) def_reload <= pwdata[15:0];
      else                            def_presc  <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEF_PRESC) ? {16'd0, def_presc} : {16'd0, def_reload};

  apc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apc_dp #(.FRAME_DEPTH(FRAME_DEPTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (s_tuser),
    .in_byte       (s_tdata[7:0]),
    .in_level      (s_tdata[8]),
    .in_rpm        (s_tdata[28:9]),
    .def_presc     (def_presc),
    .def_reload    (def_reload),
    .z_divisor     (z_divisor),
    .div_done      (div_done),
    .div_quot      (div_quot),
    .compare_value (compare_value),
    .active_low    (active_low),
    .prescaler     (prescaler),
    .reload        (reload),
    .servo_mode    (servo_mode),
    .timer_restart (timer_restart),
    .reply_valid   (reply_valid),
    .reply_value   (reply_value)
  );

  apc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (z_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign m_tdata = {5'd0, reply_value, reply_valid, timer_restart, servo_mode,
                    reload, prescaler, active_low, compare_value};
endmodule
`default_nettype wire

FILE: rtl/apc_div.sv
// Iterative restoring divider: fixed dividend over a 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module apc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [18:0]      quotient
);
  import apc_pkg::*;

  logic [15:0] dvs;
  logic [18:0] dvd;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem, dvd[18]} ;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      dvd      <= DIV_DIVIDEND;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[17:0], 1'b0};
      if (trial >= {2'b00, dvs}) begin
        rem      <= 17'(trial - {2'b00, dvs});
        quotient <= {quotient[17:0], 1'b1};
      end else begin
        rem      <= trial[16:0];
        quotient <= {quotient[17:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/apc_ctrl.sv
// Controller: sequences capture, execute, optional division and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module apc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire apc_pkg::ctrl_stat_t stat,
  output apc_pkg::ctrl_cmd_t       cmd
);
  import apc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.capture   = in_valid && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.z_cmd) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule
`default_nettype wire

FILE: rtl/apc_dp.sv
// Datapath: framing, argument parse, timer settings, pulse countdown and reply.
`timescale 1ns / 1ps
`default_nettype none
module apc_dp #(
  parameter int FRAME_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire apc_pkg::ctrl_cmd_t  cmd,
  output apc_pkg::ctrl_stat_t      stat,
  input  wire logic                in_op,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_level,
  input  wire logic [19:0]         in_rpm,
  input  wire logic [15:0]         def_presc,
  input  wire logic [15:0]         def_reload,
  output logic [15:0]              z_divisor,
  input  wire logic                div_done,
  input  wire logic [18:0]         div_quot,
  output logic [7:0]               compare_value,
  output logic                     active_low,
  output logic [18:0]              prescaler,
  output logic [15:0]              reload,
  output logic                     servo_mode,
  output logic                     timer_restart,
  output logic                     reply_valid,
  output logic [19:0]              reply_value
);
  import apc_pkg::*;

  localparam int LEN_W = $clog2(FRAME_DEPTH + 1);

  // held item
  logic        op_q;
  logic [7:0]  byte_q;
  logic        lvl_q;
  logic [19:0] rpm_q;

  logic             in_frame, in_frame_next;
  logic [LEN_W-1:0] frame_len, frame_len_next;
  logic [7:0]       letter, letter_next;
  logic [15:0]      arg, arg_next;
  logic             arg_bad, arg_bad_next;
  logic [7:0]       cmp, cmp_next;
  logic             pol, pol_next;
  logic [18:0]      presc, presc_next;
  logic [15:0]      rld, rld_next;
  logic             servo, servo_next;
  logic             pulse_on, pulse_on_next;
  logic [21:0]      pulse_rem, pulse_rem_next;
  logic             restart_next, rvalid_next;
  logic [19:0]      rvalue_next;

  logic        exec_go, servo_exit, is_digit;
  logic [15:0] a, a_p;
  logic [19:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_op;
      byte_q <= in_byte;
      lvl_q  <= in_level;
      rpm_q  <= in_rpm;
    end
  end

  assign exec_go = (op_q == OP_BYTE) && (byte_q == CH_BANG) && in_frame && (frame_len != '0);
  assign a = (arg_bad || frame_len < LEN_W'(2)) ? 16'd0 : arg;
  assign servo_exit = exec_go && servo &&
                      (letter == CH_S || letter == CH_P || letter == CH_F ||
                       letter == CH_W || letter == CH_Z);
  assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign acc = ({4'd0, arg} << 3) + ({4'd0, arg} << 1) + {12'd0, byte_q - CH_ZERO};
  assign a_p = (a == 16'd0) ? 16'd1 : ((a > P_MAX) ? P_MAX : a);
  assign z_divisor = (a < Z_MIN) ? Z_MIN : ((a > Z_MAX) ? Z_MAX : a);

  assign stat.z_cmd    = exec_go && (letter == CH_Z);
  assign stat.div_done = div_done;

  always_comb begin
    in_frame_next  = in_frame;
    frame_len_next = frame_len;
    letter_next    = letter;
    arg_next       = arg;
    arg_bad_next   = arg_bad;
    cmp_next       = cmp;
    pol_next       = pol;
    presc_next     = presc;
    rld_next       = rld;
    servo_next     = servo;
    pulse_on_next  = pulse_on;
    pulse_rem_next = pulse_rem;
    restart_next   = timer_restart;
    rvalid_next    = reply_valid;
    rvalue_next    = reply_value;

    if (cmd.exec) begin
      restart_next = 1'b0;
      rvalid_next  = 1'b0;
      rvalue_next  = '0;
      if (op_q == OP_TICK) begin
        if (pulse_on) begin
          if (pulse_rem <= 22'd1) begin
            pulse_rem_next = '0;
            pulse_on_next  = 1'b0;
            cmp_next       = '0;
          end else begin
            pulse_rem_next = pulse_rem - 22'd1;
          end
        end
      end else begin
        if (exec_go) begin
          if (servo_exit) begin
            cmp_next     = '0;
            restart_next = 1'b1;
            presc_next   = {3'd0, def_presc};
            rld_next     = def_reload;
            pol_next     = 1'b0;
            servo_next   = 1'b0;
          end
          case (letter)
            CH_S: begin
              pol_next = 1'b0;
              cmp_next = (a != 16'd0) ? CMP_FULL : 8'd0;
            end
            CH_P: begin
              pol_next       = 1'b0;
              cmp_next       = CMP_PULSE;
              pulse_on_next  = 1'b1;
              pulse_rem_next = ({6'd0, a_p} << 6) + ({6'd0, a_p} << 5) + ({6'd0, a_p} << 2);
            end
            CH_F: begin
              pol_next = 1'b1;
              cmp_next = (a > 16'(CMP_FULL)) ? CMP_FULL : a[7:0];
            end
            CH_W: begin
              pol_next = 1'b0;
              cmp_next = (a > 16'(CMP_FULL)) ? CMP_FULL : a[7:0];
            end
            CH_A: begin
              if (!servo) begin
                restart_next = 1'b1;
                presc_next   = SERVO_PRESC;
                rld_next     = SERVO_RELOAD;
                pol_next     = 1'b1;
                servo_next   = 1'b1;
              end
              cmp_next = (a > 16'(CMP_SERVO_MAX)) ? CMP_SERVO_MAX : a[7:0];
            end
            CH_I: begin
              rvalid_next = 1'b1;
              rvalue_next = {19'd0, lvl_q};
            end
            CH_T: begin
              rvalid_next = 1'b1;
              rvalue_next = rpm_q;
            end
            CH_O: begin
              rvalid_next = 1'b1;
              rvalue_next = {12'd0, cmp};
            end
            default: ;
          endcase
        end

        // framing, in the order: close, overflow drop, store, restart
        if ((byte_q == CH_BANG) && in_frame) in_frame_next = 1'b0;
        if (frame_len >= LEN_W'(FRAME_DEPTH)) begin
          in_frame_next  = 1'b0;
          frame_len_next = '0;
        end
        if (in_frame_next) begin
          if (frame_len_next == '0) begin
            letter_next  = byte_q;
            arg_next     = '0;
            arg_bad_next = 1'b0;
          end else if (is_digit) begin
            arg_next = (acc > {4'd0, ARG_SAT}) ? ARG_SAT : acc[15:0];
          end else begin
            arg_bad_next = 1'b1;
          end
          frame_len_next = frame_len_next + LEN_W'(1);
        end
        if (byte_q == CH_HASH) begin
          frame_len_next = '0;
          in_frame_next  = 1'b1;
        end
      end
    end

    if (cmd.div_load) presc_next = div_quot - 19'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      frame_len     <= '0;
      letter        <= '0;
      arg           <= '0;
      arg_bad       <= 1'b0;
      cmp           <= '0;
      pol           <= 1'b0;
      presc         <= '0;
      rld           <= RELOAD_RST;
      servo         <= 1'b0;
      pulse_on      <= 1'b0;
      pulse_rem     <= '0;
      timer_restart <= 1'b0;
      reply_valid   <= 1'b0;
      reply_value   <= '0;
    end else begin
      in_frame      <= in_frame_next;
      frame_len     <= frame_len_next;
      letter        <= letter_next;
      arg           <= arg_next;
      arg_bad       <= arg_bad_next;
      cmp           <= cmp_next;
      pol           <= pol_next;
      presc         <= presc_next;
      rld           <= rld_next;
      servo         <= servo_next;
      pulse_on      <= pulse_on_next;
      pulse_rem     <= pulse_rem_next;
      timer_restart <= restart_next;
      reply_valid   <= rvalid_next;
      reply_value   <= rvalue_next;
    end
  end

  assign compare_value = cmp;
  assign active_low    = pol;
  assign prescaler     = presc;
  assign reload        = rld;
  assign servo_mode    = servo;
endmodule
`default_nettype wire

FILE: rtl/apc_checker.sv
// Port-level checker for the command PWM controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_command_pwm_controller_assert.svh"
module apc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);
  `APC_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready)
  `APC_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !m_tvalid && !s_tready)
  `APC_ASSERT_NOW(a_reply_zero, m_tvalid && !m_tdata[46], m_tdata[66:47] == 20'd0)
  `APC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind ascii_command_pwm_controller apc_checker u_apc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
